[hw/rtl/watchpoint_range_match_table_macros.svh]
// Assertion macros for the watchpoint range match table.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef WATCHPOINT_RANGE_MATCH_TABLE_MACROS_SVH
`define WATCHPOINT_RANGE_MATCH_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WRMT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WRMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/wrmt_pkg.sv]
// Package of the watchpoint range match table: field widths, codes and payload types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package wrmt_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned ADDR_BITS   = 27;
  localparam int unsigned LEN_BITS    = ADDR_BITS + 1;
  localparam int unsigned END_BITS    = ADDR_BITS + 2;
  localparam int unsigned ID_BITS     = 16;
  localparam int unsigned TYPE_BITS   = 3;

  typedef enum logic [1:0] {
    KIND_CHECK  = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]           kind;
    logic [ADDR_BITS-1:0] addr;
    logic [LEN_BITS-1:0]  length;
    logic [TYPE_BITS-1:0] access_type;
    logic [ID_BITS-1:0]   select_id;
  } in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic                 hit;
    logic [ID_BITS-1:0]   result_id;
    logic [TYPE_BITS-1:0] hit_type;
  } out_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [LEN_BITS-1:0]  length;
    logic [TYPE_BITS-1:0] etype;
    logic [ID_BITS-1:0]   ident;
  } entry_t;

endpackage

[hw/rtl/wrmt_scan.sv]
// Range scan of the watchpoint table: parallel overlap compares and a minimum tree.
// Depends on wrmt_pkg for the entry type and the address widths.
`timescale 1ns / 1ps

module wrmt_scan #(
  parameter int unsigned ENTRIES = wrmt_pkg::ENTRIES_DEF,
  localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                                  en_i,
  input  logic [wrmt_pkg::ADDR_BITS-1:0]        start_i,
  input  logic [wrmt_pkg::END_BITS-1:0]         end_i,
  input  logic [wrmt_pkg::TYPE_BITS-1:0]        type_i,
  input  logic [ENTRIES-1:0]                    valid_i,
  input  wrmt_pkg::entry_t [ENTRIES-1:0]        ent_i,
  output logic                                  found_o,
  output logic [IDX_W-1:0]                      idx_o
);
  import wrmt_pkg::*;

  localparam int unsigned LVL   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned N     = 1 << LVL;
  localparam int unsigned KEY_W = ADDR_BITS + ID_BITS;

  logic             nd_vld [LVL+1][N];
  logic [KEY_W-1:0] nd_key [LVL+1][N];
  logic [IDX_W-1:0] nd_idx [LVL+1][N];

  // The key orders by start address first and by ID second.
  always_comb begin
    for (int l = 0; l <= LVL; l++) begin
      for (int i = 0; i < N; i++) begin
        nd_vld[l][i] = 1'b0;
        nd_key[l][i] = '0;
        nd_idx[l][i] = '0;
      end
    end
    for (int i = 0; i < ENTRIES; i++) begin
      nd_vld[0][i] = en_i && valid_i[i] && ((ent_i[i].etype & type_i) != '0)
                     && ({2'b00, ent_i[i].start} < end_i)
                     && (({2'b00, ent_i[i].start} + {1'b0, ent_i[i].length})
                         > {2'b00, start_i});
      nd_key[0][i] = {ent_i[i].start, ent_i[i].ident};
      nd_idx[0][i] = IDX_W'(i);
    end
    for (int l = 0; l < LVL; l++) begin
      for (int i = 0; i < (N >> (l + 1)); i++) begin
        if (nd_vld[l][2*i] &&
            (!nd_vld[l][2*i+1] || nd_key[l][2*i] <= nd_key[l][2*i+1])) begin
          nd_vld[l+1][i] = 1'b1;
          nd_key[l+1][i] = nd_key[l][2*i];
          nd_idx[l+1][i] = nd_idx[l][2*i];
        end else begin
          nd_vld[l+1][i] = nd_vld[l][2*i+1];
          nd_key[l+1][i] = nd_key[l][2*i+1];
          nd_idx[l+1][i] = nd_idx[l][2*i+1];
        end
      end
    end
  end

  assign found_o = nd_vld[LVL][0];
  assign idx_o   = nd_idx[LVL][0];

endmodule

[hw/rtl/watchpoint_range_match_table.sv]
// Top level of the watchpoint range match table: input register, table, result register.
// Depends on wrmt_pkg, wrmt_scan and watchpoint_range_match_table_macros.svh.
`timescale 1ns / 1ps

// How to use this block:
// The input channel (in_valid_i, in_stall_o, in_data_i) carries one command per
// transfer: check an access, add a breakpoint or remove a breakpoint by its ID.
// The output channel (out_valid_o, out_stall_i, out_data_o) returns exactly one
// result per command, in command order.
// A command is captured in an input register at its transfer. Once the result
// register is free or its item is being taken, the command is decoded, compared
// against every table entry in parallel and its result is loaded into the output
// register, while adds and removes update the table at that same edge, so the next
// command already sees the updated table. Throughput is one command per cycle while
// the receiver does not stall, set by the single pass through the parallel
// comparators and the minimum tree between the two registers.
// When the receiver stalls, the result register holds its item and the input
// register can still take one more command; once both are full, in_stall_o
// rises until the result is taken.
// Reset clears every valid bit of the table and empties both registers.
// Entry contents are not reset; they are only read while their valid bit is set.
module watchpoint_range_match_table #(
  parameter int unsigned ENTRIES = wrmt_pkg::ENTRIES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  wrmt_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output wrmt_pkg::out_t  out_data_o
);
  import wrmt_pkg::*;

  `include "watchpoint_range_match_table_macros.svh"

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned LVL   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned N     = 1 << LVL;
  localparam logic [END_BITS-1:0] MEM_SIZE = END_BITS'(1) << ADDR_BITS;

  // Pipeline registers.
  logic   in_vld_q;
  in_t    in_q;
  logic   out_vld_q;
  out_t   out_q;
  out_t   res_d;
  logic   fire;

  // Table storage.
  logic   [ENTRIES-1:0] valid_q;
  logic   [ENTRIES-1:0] valid_d;
  entry_t [ENTRIES-1:0] ent_q;
  logic   [ENTRIES-1:0] ent_we;
  entry_t               ent_new;

  // Processing happens when a command waits and the result register is free or its item is being taken.
  assign fire        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o  = in_vld_q && !fire;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_vld_q <= 1'b1;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
    if (fire) begin
      out_q <= res_d;
    end
  end

  // Access range split. An access that runs past the top of memory is checked
  // in two parts, and a hit in the wrapped low part at address zero takes
  // precedence over one in the part from its start up to the top of memory.
  logic [END_BITS-1:0] acc_end;
  logic [END_BITS-1:0] low_end_raw;
  logic [END_BITS-1:0] low_end;
  logic [END_BITS-1:0] high_end;
  logic                wrap;

  assign acc_end     = {2'b00, in_q.addr} + {1'b0, in_q.length};
  assign wrap        = acc_end > MEM_SIZE;
  assign low_end_raw = acc_end - MEM_SIZE;
  assign low_end     = (low_end_raw > MEM_SIZE) ? MEM_SIZE : low_end_raw;
  assign high_end    = wrap ? MEM_SIZE : acc_end;

  logic             low_found;
  logic [IDX_W-1:0] low_idx;
  logic             high_found;
  logic [IDX_W-1:0] high_idx;
  logic             win_found;
  logic [IDX_W-1:0] win_idx;

  wrmt_scan #(
    .ENTRIES (ENTRIES)
  ) u_scan_low (
    .en_i    (wrap),
    .start_i ('0),
    .end_i   (low_end),
    .type_i  (in_q.access_type),
    .valid_i (valid_q),
    .ent_i   (ent_q),
    .found_o (low_found),
    .idx_o   (low_idx)
  );

  wrmt_scan #(
    .ENTRIES (ENTRIES)
  ) u_scan_high (
    .en_i    (1'b1),
    .start_i (in_q.addr),
    .end_i   (high_end),
    .type_i  (in_q.access_type),
    .valid_i (valid_q),
    .ent_i   (ent_q),
    .found_o (high_found),
    .idx_o   (high_idx)
  );

  assign win_found = low_found || high_found;
  assign win_idx   = low_found ? low_idx : high_idx;

  // Highest live ID, through a tree of pairwise maxima.
  logic [ID_BITS-1:0] mx [LVL+1][N];
  logic [ID_BITS-1:0] top_id;

  always_comb begin
    for (int l = 0; l <= LVL; l++) begin
      for (int i = 0; i < N; i++) begin
        mx[l][i] = '0;
      end
    end
    for (int i = 0; i < ENTRIES; i++) begin
      mx[0][i] = valid_q[i] ? ent_q[i].ident : '0;
    end
    for (int l = 0; l < LVL; l++) begin
      for (int i = 0; i < (N >> (l + 1)); i++) begin
        mx[l+1][i] = (mx[l][2*i] >= mx[l][2*i+1]) ? mx[l][2*i] : mx[l][2*i+1];
      end
    end
  end

  assign top_id = mx[LVL][0];

  // The lowest free slot is isolated as a one-hot mask.
  logic [ENTRIES-1:0] free;
  logic [ENTRIES-1:0] free_first;
  logic               add_fail;
  logic [ENTRIES-1:0] rm_match;
  logic               rm_found;

  assign free       = ~valid_q;
  assign free_first = free & (~free + ENTRIES'(1));
  assign add_fail   = (free == '0) || (&top_id);

  // Live IDs are unique, so at most one entry matches a remove.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      rm_match[i] = valid_q[i] && (ent_q[i].ident == in_q.select_id);
    end
  end
  assign rm_found = rm_match != '0;

  assign ent_new.start  = in_q.addr;
  assign ent_new.length = in_q.length;
  assign ent_new.etype  = in_q.access_type;
  assign ent_new.ident  = top_id + ID_BITS'(1);

  always_comb begin
    res_d   = '0;
    valid_d = valid_q;
    ent_we  = '0;
    unique case (kind_e'(in_q.kind))
      KIND_CHECK: begin
        res_d.status = STATUS_OK;
        if (win_found) begin
          res_d.hit       = 1'b1;
          res_d.result_id = ent_q[win_idx].ident;
          res_d.hit_type  = ent_q[win_idx].etype;
        end
      end
      KIND_ADD: begin
        if (add_fail) begin
          res_d.status = STATUS_FULL;
        end else begin
          res_d.status    = STATUS_OK;
          res_d.result_id = ent_new.ident;
          ent_we          = free_first;
          valid_d         = valid_q | free_first;
        end
      end
      KIND_REMOVE: begin
        if (rm_found) begin
          res_d.status = STATUS_OK;
          valid_d      = valid_q & ~rm_match;
        end else begin
          res_d.status = STATUS_NOT_FOUND;
        end
      end
      default: begin
        res_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (fire) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (fire && ent_we[i]) begin
        ent_q[i] <= ent_new;
      end
    end
  end

  // A full pipeline with a stalled receiver must hold off the sender.
  `WRMT_ASSERT_SAME(a_stall_when_full, in_vld_q && out_vld_q && out_stall_i, in_stall_o,
                    "input not stalled while both registers are full")
  // A hit reports a live, nonzero ID with status ok.
  `WRMT_ASSERT_SAME(a_hit_has_id, out_valid_o && out_data_o.hit,
                    (out_data_o.status == STATUS_OK) && (out_data_o.result_id != '0),
                    "hit without a valid ID or with a nonzero status")
  // A successful add occupies exactly one more slot.
  `WRMT_ASSERT_NEXT(a_add_one_slot,
                    fire && (in_q.kind == KIND_ADD) && !add_fail,
                    $countones(valid_q) == $countones($past(valid_q)) + 1,
                    "successful add did not fill exactly one slot")
  // A successful remove frees exactly one slot.
  `WRMT_ASSERT_NEXT(a_remove_one_slot,
                    fire && (in_q.kind == KIND_REMOVE) && rm_found,
                    $countones(valid_q) + 1 == $countones($past(valid_q)),
                    "successful remove did not free exactly one slot")

endmodule

[test/testbench.sv]
// Self-checking testbench for watchpoint_range_match_table: a directed stimulus table,
// a table fill and a random command mix.
// Depends on wrmt_pkg and the block's RTL; each reply is scored by a behavioral model or a typed value.
`timescale 1ns / 1ps

module testbench;
  import wrmt_pkg::*;

  localparam int unsigned SLOTS = ENTRIES_DEF;

  // Memory size as an end-of-range value, wide enough for start plus length.
  localparam logic [END_BITS-1:0]  MEM_TOP  = {2'b01, {ADDR_BITS{1'b0}}};
  localparam logic [LEN_BITS-1:0]  LEN_FULL = {1'b1, {ADDR_BITS{1'b0}}};
  localparam logic [ADDR_BITS-1:0] ADDR_TOP = '1;
  localparam logic [ID_BITS-1:0]   ID_LAST  = '1;

  // The fourth kind code is not an operation; the block must answer it with zeros.
  localparam logic [1:0] KIND_NOP = 2'd3;

  localparam logic [TYPE_BITS-1:0] T_NONE  = 3'b000;
  localparam logic [TYPE_BITS-1:0] T_READ  = 3'b001;
  localparam logic [TYPE_BITS-1:0] T_WRITE = 3'b010;
  localparam logic [TYPE_BITS-1:0] T_EXEC  = 3'b100;
  localparam logic [TYPE_BITS-1:0] T_ALL   = 3'b111;

  localparam out_t NO_REPLY = '0;
  localparam int   PLAN_ROWS = 25;
  localparam int   RANDOM_ITEMS = 1800;

  // One directed row: the command, and the reply when it is obvious enough to type in.
  typedef struct packed {
    in_t  cmd;
    logic typed;
    out_t want;
  } plan_row_t;

  // One reply still owed by the block, kept with its command for reporting.
  typedef struct packed {
    in_t  cmd;
    out_t want;
  } owed_reply_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  watchpoint_range_match_table u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Breakpoint table model. Reset only clears the live bits, so the entry
  // contents start unknown and are read only while their slot is live.
  // ---------------------------------------------------------------------------
  bit     bp_live [SLOTS];
  entry_t bp_tab  [SLOTS];

  owed_reply_t owed_replies [$];
  int unsigned fail_count = 0;
  int unsigned burst_left = 0;
  int unsigned stall_cycle = 0;
  int unsigned stall_mode = 0;
  plan_row_t   plan [PLAN_ROWS];

  // Finds the winning live slot for the access [lo, lo+span) and the given type
  // mask, or -1. Overlap is strict on both sides, so an access of length zero
  // still hits an entry that starts below it and covers it. The lowest start
  // wins and a tie goes to the lowest ID.
  function automatic int winning_slot(input logic [END_BITS-1:0] lo,
                                      input logic [END_BITS-1:0] span,
                                      input logic [TYPE_BITS-1:0] mask);
    int best = -1;
    logic [END_BITS-1:0] s, e, bs;
    for (int i = 0; i < SLOTS; i++) begin
      if (!bp_live[i] || (bp_tab[i].etype & mask) == T_NONE) continue;
      s = bp_tab[i].start;
      e = s + bp_tab[i].length;
      if (!(s < lo + span && e > lo)) continue;
      if (best >= 0) bs = bp_tab[best].start;
      if (best < 0 || s < bs || (s == bs && bp_tab[i].ident < bp_tab[best].ident)) begin
        best = i;
      end
    end
    return best;
  endfunction

  // Computes the block's reply to one command and applies the command to the
  // model table, exactly as the block does at the same transfer.
  function automatic out_t table_response(input in_t cmd);
    out_t r;
    int w, slot;
    logic [END_BITS-1:0] a, span, low;
    logic [ID_BITS-1:0] top;
    r = '0;
    case (cmd.kind)
      KIND_CHECK: begin
        a = cmd.addr;
        span = cmd.length;
        w = -1;
        // An access past the top of memory wraps; its low part at address 0
        // is searched first and its winner takes precedence.
        if (a + span > MEM_TOP) begin
          low = a + span - MEM_TOP;
          if (low > MEM_TOP) low = MEM_TOP;
          w = winning_slot('0, low, cmd.access_type);
          span = MEM_TOP - a;
        end
        if (w < 0) w = winning_slot(a, span, cmd.access_type);
        if (w >= 0) begin
          r.hit = 1'b1;
          r.result_id = bp_tab[w].ident;
          r.hit_type = bp_tab[w].etype;
        end
      end
      KIND_ADD: begin
        // The lowest free slot gets ID one above the highest live ID.
        slot = -1;
        top = '0;
        for (int i = 0; i < SLOTS; i++) begin
          if (bp_live[i]) begin
            if (bp_tab[i].ident > top) top = bp_tab[i].ident;
          end else if (slot < 0) begin
            slot = i;
          end
        end
        if (slot < 0 || top == ID_LAST) begin
          r.status = STATUS_FULL;
        end else begin
          bp_live[slot] = 1'b1;
          bp_tab[slot] = '{start: cmd.addr, length: cmd.length,
                           etype: cmd.access_type, ident: top + 1'b1};
          r.result_id = top + 1'b1;
        end
      end
      KIND_REMOVE: begin
        slot = -1;
        for (int i = 0; i < SLOTS; i++) begin
          if (slot < 0 && bp_live[i] && bp_tab[i].ident == cmd.select_id) slot = i;
        end
        if (slot < 0) r.status = STATUS_NOT_FOUND;
        else bp_live[slot] = 1'b0;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic int live_count();
    int n = 0;
    foreach (bp_live[i]) n += bp_live[i];
    return n;
  endfunction

  // Picks a random live slot whose ID differs from skip, or -1 when there is none.
  // ID zero is never live, so passing zero skips nothing.
  function automatic int pick_live_slot(input logic [ID_BITS-1:0] skip);
    int cand [$];
    foreach (bp_live[i]) begin
      if (bp_live[i] && bp_tab[i].ident != skip) cand.push_back(i);
    end
    if (cand.size() == 0) return -1;
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  function automatic in_t make_cmd(input logic [1:0] kind,
                                   input logic [ADDR_BITS-1:0] addr,
                                   input logic [LEN_BITS-1:0] length,
                                   input logic [TYPE_BITS-1:0] atype,
                                   input logic [ID_BITS-1:0] sel);
    in_t c;
    c.kind = kind;
    c.addr = addr;
    c.length = length;
    c.access_type = atype;
    c.select_id = sel;
    return c;
  endfunction

  function automatic out_t make_reply(input logic [1:0] status, input logic hit,
                                      input logic [ID_BITS-1:0] id,
                                      input logic [TYPE_BITS-1:0] htype);
    out_t r;
    r.status = status;
    r.hit = hit;
    r.result_id = id;
    r.hit_type = htype;
    return r;
  endfunction

  // Addresses cluster at the bottom, at the top and in the middle of memory so
  // that random breakpoints and accesses meet often; a quarter are uniform.
  function automatic logic [ADDR_BITS-1:0] rand_addr();
    case ($urandom_range(0, 3))
      0: return ADDR_BITS'($urandom_range(0, 511));
      1: return ADDR_TOP - ADDR_BITS'($urandom_range(0, 511));
      2: return ADDR_BITS'(32'h400_0000 + $urandom_range(0, 511) - 256);
      default: return ADDR_BITS'($urandom());
    endcase
  endfunction

  // Lengths are mostly short, with the odd huge one and the full memory size.
  function automatic logic [LEN_BITS-1:0] rand_len();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return LEN_BITS'($urandom_range(0, 64));
      5, 6: return LEN_BITS'($urandom_range(0, 4096));
      7: return LEN_BITS'($urandom_range(0, 32'h800_0000));
      8: return $urandom_range(0, 1) ? LEN_FULL : '0;
      default: return LEN_FULL - LEN_BITS'($urandom_range(1, 64));
    endcase
  endfunction

  // A random command. Adds grow more likely as the table empties, so the
  // occupancy wanders over the whole range. Most removes name a live ID and
  // half of the checks are aimed near a live breakpoint.
  function automatic in_t rand_cmd();
    in_t c;
    int pick, s;
    c = make_cmd(KIND_CHECK, rand_addr(), rand_len(), TYPE_BITS'($urandom_range(0, 7)),
                 ID_BITS'($urandom()));
    pick = $urandom_range(0, 99);
    s = pick_live_slot('0);
    if (pick < 4) begin
      c.kind = KIND_NOP;
    end else if (pick < 52) begin
      if (s >= 0 && $urandom_range(0, 1) == 1) begin
        c.addr = bp_tab[s].start + ADDR_BITS'($urandom_range(0, 64)) - ADDR_BITS'(32);
      end
    end else if ($urandom_range(0, SLOTS - 1) >= live_count()) begin
      c.kind = KIND_ADD;
    end else begin
      c.kind = KIND_REMOVE;
      if (s >= 0 && $urandom_range(0, 9) != 0) c.select_id = bp_tab[s].ident;
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Commands go out in bursts of random length; between most bursts the
  // valid line drops. Occasionally a long burst runs with no gaps at all. The
  // expected reply is queued before the transfer, which is safe because the reply
  // can appear only after the input register has taken the command.
  // ---------------------------------------------------------------------------
  task automatic transfer(input in_t cmd, input out_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    owed_replies.push_back('{cmd: cmd, want: want});
    in_valid_i <= 1'b1;
    in_data_i <= cmd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    burst_left--;
  endtask

  task automatic issue(input in_t cmd);
    out_t want;
    want = table_response(cmd);
    transfer(cmd, want);
  endtask

  // Holds the input idle until every owed reply has been taken.
  task automatic await_drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (owed_replies.size() != 0);
  endtask

  task automatic note_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got, input in_t cmd);
    fail_count++;
    $display("%0t: %s mismatch (kind %0d addr %h len %h type %b sel %0d): expected %0h, got %0h",
             $time, field, cmd.kind, cmd.addr, cmd.length, cmd.access_type,
             cmd.select_id, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver. Each reply transfer is compared field by field with the oldest
  // owed reply. Signals are sampled at the clock edge, so they hold the values
  // from before the edge. The stall line follows a pattern of its own that is
  // switched at random among four modes: never, light random, heavy random and a
  // fixed periodic stall.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : score_replies
    owed_reply_t head;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (owed_replies.size() == 0) begin
        note_mismatch("unexpected reply", '0, out_data_o, in_data_i);
      end else begin
        head = owed_replies.pop_front();
        if (out_data_o.status !== head.want.status)
          note_mismatch("status", head.want.status, out_data_o.status, head.cmd);
        if (out_data_o.hit !== head.want.hit)
          note_mismatch("hit", head.want.hit, out_data_o.hit, head.cmd);
        if (out_data_o.result_id !== head.want.result_id)
          note_mismatch("result_id", head.want.result_id, out_data_o.result_id, head.cmd);
        if (out_data_o.hit_type !== head.want.hit_type)
          note_mismatch("hit_type", head.want.hit_type, out_data_o.hit_type, head.cmd);
      end
    end
    stall_cycle++;
    if (stall_cycle % 300 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= ((stall_cycle % 7) < 3);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    in_t c;
    out_t want;
    int counted;

    // Directed part. The table starts empty; typed replies are the ones that
    // follow directly from the rules (empty table, fresh IDs, error codes).
    plan = '{
      // Nothing can match in an empty table, even the whole of memory.
      '{make_cmd(KIND_CHECK, '0, LEN_FULL, T_ALL, '0), 1'b1, NO_REPLY},
      '{make_cmd(KIND_REMOVE, '0, '0, T_NONE, ID_LAST), 1'b1,
        make_reply(STATUS_NOT_FOUND, 1'b0, '0, T_NONE)},
      // The undefined kind with every field at its top answers zeros.
      '{make_cmd(KIND_NOP, ADDR_TOP, LEN_FULL, T_ALL, ID_LAST), 1'b1, NO_REPLY},
      '{make_cmd(KIND_ADD, '0, 'h10, T_READ, '0), 1'b1,
        make_reply(STATUS_OK, 1'b0, 16'd1, T_NONE)},
      '{make_cmd(KIND_ADD, 'h7FF_FFF0, 'h10, T_WRITE, '0), 1'b1,
        make_reply(STATUS_OK, 1'b0, 16'd2, T_NONE)},
      // A breakpoint that runs past the top of memory.
      '{make_cmd(KIND_ADD, 'h400_0000, LEN_FULL, T_EXEC, '0), 1'b1,
        make_reply(STATUS_OK, 1'b0, 16'd3, T_NONE)},
      // Same start as ID 1, so ties are decided by ID.
      '{make_cmd(KIND_ADD, '0, 'h8, T_ALL, '0), 1'b1,
        make_reply(STATUS_OK, 1'b0, 16'd4, T_NONE)},
      // A breakpoint of length zero.
      '{make_cmd(KIND_ADD, 'h100, '0, T_READ | T_WRITE, '0), 1'b1,
        make_reply(STATUS_OK, 1'b0, 16'd5, T_NONE)},
      // Accesses that wrap past the top: the low part at address 0 wins.
      '{make_cmd(KIND_CHECK, 'h7FF_FFF8, 'h10, T_READ, '0), 1'b0, NO_REPLY},
      '{make_cmd(KIND_CHECK, 'h7FF_FFF8, 'h10, T_WRITE, '0), 1'b0, NO_REPLY},
      // A zero-length access inside a breakpoint.
      '{make_cmd(KIND_CHECK, 'h5, '0, T_READ, '0), 1'b0, NO_REPLY},
      '{make_cmd(KIND_CHECK, 'h50, 'hB0, T_READ, '0), 1'b0, NO_REPLY},
      '{make_cmd(KIND_CHECK, 'hFF, 'h2, T_WRITE, '0), 1'b0, NO_REPLY},
      '{make_cmd(KIND_CHECK, 'h600_0000, 'h1, T_EXEC, '0), 1'b0, NO_REPLY},
      // Top address with the full length wraps over almost all of memory.
      '{make_cmd(KIND_CHECK, ADDR_TOP, LEN_FULL, T_ALL, '0), 1'b0, NO_REPLY},
      // An access that ends exactly at the top does not wrap.
      '{make_cmd(KIND_CHECK, 'h7FF_FFF0, 'h10, T_WRITE, '0), 1'b0, NO_REPLY},
      // Adjacent to the end of a breakpoint, which is not an overlap.
      '{make_cmd(KIND_CHECK, 'h10, 'h10, T_READ, '0), 1'b0, NO_REPLY},
      '{make_cmd(KIND_REMOVE, '0, '0, T_NONE, 16'd1), 1'b1, NO_REPLY},
      '{make_cmd(KIND_CHECK, '0, 'h1, T_READ, '0), 1'b0, NO_REPLY},
      '{make_cmd(KIND_REMOVE, '0, '0, T_NONE, 16'd1), 1'b1,
        make_reply(STATUS_NOT_FOUND, 1'b0, '0, T_NONE)},
      // ID zero is never live.
      '{make_cmd(KIND_REMOVE, '0, '0, T_NONE, '0), 1'b1,
        make_reply(STATUS_NOT_FOUND, 1'b0, '0, T_NONE)},
      '{make_cmd(KIND_ADD, 'h1000, 'h4, T_READ, '0), 1'b1,
        make_reply(STATUS_OK, 1'b0, 16'd6, T_NONE)},
      '{make_cmd(KIND_REMOVE, '0, '0, T_NONE, 16'd6), 1'b1, NO_REPLY},
      // The freed top ID is handed out again.
      '{make_cmd(KIND_ADD, ADDR_TOP, LEN_FULL, T_ALL, '0), 1'b1,
        make_reply(STATUS_OK, 1'b0, 16'd6, T_NONE)},
      // An access with an empty type mask never matches.
      '{make_cmd(KIND_CHECK, '0, LEN_FULL, T_NONE, '0), 1'b1, NO_REPLY}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      want = table_response(plan[i].cmd);
      transfer(plan[i].cmd, plan[i].typed ? plan[i].want : want);
    end

    // Fill every slot, then one more add must report a full table.
    while (live_count() < SLOTS) begin
      issue(make_cmd(KIND_ADD, rand_addr(), rand_len(), TYPE_BITS'($urandom_range(1, 7)),
                     ID_BITS'($urandom())));
    end
    issue(make_cmd(KIND_ADD, rand_addr(), rand_len(), T_ALL, '0));

    // Let the block run completely dry once before the random mix.
    await_drain();

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      c = rand_cmd();
      issue(c);
      if (c.kind != KIND_NOP) counted++;
    end

    // Wait for the last replies, then a few cycles more for anything stray.
    await_drain();
    repeat (4) @(posedge clk_i);

    if (fail_count == 0 && owed_replies.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run under the heaviest stalls.
  initial begin : watchdog
    #2_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
